@@ hw/rtl/sequence_reorder_gap_release_core_assert.svh @@
// Assertion macros used by the reorder buffer back end (srgr_back).
// Uses clk and rst_n of the including module.
`ifndef SEQUENCE_REORDER_GAP_RELEASE_CORE_ASSERT_SVH
`define SEQUENCE_REORDER_GAP_RELEASE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SRGR_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define SRGR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SRGR_ASSERT_ALWAYS(lbl, cond)
`define SRGR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/srgr_pkg.sv @@
// Shared types and constants of the sequence reorder buffer.
// No dependencies.
package srgr_pkg;
  typedef enum logic [2:0] {
    B_IDLE,
    B_FIND,
    B_INS,
    B_REL,
    B_FLUSH
  } back_state_t;

  localparam logic CFG_START_SEQ  = 1'b0;
  localparam logic CFG_HOLD_LIMIT = 1'b1;
  localparam logic [5:0] HOLD_LIMIT_RESET = 6'd63;
endpackage

@@ hw/rtl/srgr_in_if.sv @@
// Input channel of the reorder buffer: valid/ready plus the update word.
// Standalone, no package use.
interface srgr_in_if #(parameter int SEQ_BITS = 48, parameter int HANDLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [SEQ_BITS-1:0]    span_first;
  logic [SEQ_BITS-1:0]    last_seq;
  logic [HANDLE_BITS-1:0] handle;
  logic                   feed;
  modport source (output valid, span_first, last_seq, handle, feed, input ready);
  modport sink (input valid, span_first, last_seq, handle, feed, output ready);
endinterface

@@ hw/rtl/srgr_out_if.sv @@
// Result channel of the reorder buffer: valid/ready plus the release word.
// Standalone, no package use.
interface srgr_out_if #(parameter int SEQ_BITS = 48, parameter int HANDLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [SEQ_BITS-1:0]    out_first_seq;
  logic [SEQ_BITS-1:0]    out_last_seq;
  logic [HANDLE_BITS-1:0] out_handle;
  logic                   out_feed;
  logic                   forced_jump;
  logic                   last_of_run;
  modport source (output valid, out_first_seq, out_last_seq, out_handle, out_feed,
                  forced_jump, last_of_run, input ready);
  modport sink (input valid, out_first_seq, out_last_seq, out_handle, out_feed,
                forced_jump, last_of_run, output ready);
endinterface

@@ hw/rtl/srgr_front.sv @@
// Front end: accepts update words into a two-entry queue for the back end.
// Depends on srgr_in_if.
module srgr_front #(
  parameter int SEQ_BITS    = 48,
  parameter int HANDLE_BITS = 16,
  parameter int QW          = 2 * SEQ_BITS + HANDLE_BITS + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  srgr_in_if.sink       in_ch,
  output logic          q_valid,
  output logic [QW-1:0] q_data,
  input  logic          q_pop
);
  logic [QW-1:0] slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;
  logic          pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = q_pop && q_valid;
  assign q_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= {in_ch.span_first, in_ch.last_seq, in_ch.handle, in_ch.feed};
    end
  end
endmodule

@@ hw/rtl/srgr_back.sv @@
// Back end: sorted hold store, insert, release pass and output register.
// Depends on srgr_pkg, srgr_out_if and the assertion macro header.
`include "sequence_reorder_gap_release_core_assert.svh"
module srgr_back #(
  parameter int HOLD_DEPTH  = 64,
  parameter int SEQ_BITS    = 48,
  parameter int HANDLE_BITS = 16,
  parameter int QW          = 2 * SEQ_BITS + HANDLE_BITS + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  logic [QW-1:0]       q_data,
  output logic                q_pop,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [SEQ_BITS-1:0] cfg_data,
  srgr_out_if.source          out_ch
);
  import srgr_pkg::*;

  localparam int CW = $clog2(HOLD_DEPTH + 1);

  logic [SEQ_BITS-1:0]    last_r   [HOLD_DEPTH];
  logic [SEQ_BITS-1:0]    first_r  [HOLD_DEPTH];
  logic [HANDLE_BITS-1:0] handle_r [HOLD_DEPTH];
  logic                   src_r    [HOLD_DEPTH];

  back_state_t state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [SEQ_BITS-1:0]    exp_r, exp_nxt;
  logic [5:0]             limit_r;
  logic [SEQ_BITS-1:0]    cur_first_r, cur_last_r;
  logic [HANDLE_BITS-1:0] cur_handle_r;
  logic                   cur_feed_r;
  logic [HOLD_DEPTH-1:0]  lt_r, lt_nxt;
  logic                   dup_r, dup_nxt;

  logic                   pend_v_r, pend_v_nxt;
  logic [SEQ_BITS-1:0]    pend_first_r, pend_last_r;
  logic [HANDLE_BITS-1:0] pend_handle_r;
  logic                   pend_feed_r, pend_forced_r, pend_forced_nxt;
  logic                   pend_load;

  logic                   out_v_r, out_v_nxt;
  logic                   out_push, out_last;
  logic                   out_busy;

  logic                   ins_en, drop_en;
  logic                   do_hold;
  logic [SEQ_BITS-1:0]    head_next_seq;

  assign out_busy      = out_v_r && !out_ch.ready;
  assign head_next_seq = last_r[0] + SEQ_BITS'(1);
  assign q_pop         = (state_r == B_IDLE) && q_valid;
  assign do_hold = !((exp_r != '0) && (cur_last_r < exp_r)) && !dup_r &&
                   (count_r < CW'(HOLD_DEPTH));

  // parallel compare against the sorted store; lt is a thermometer code
  always_comb begin
    dup_nxt = 1'b0;
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      lt_nxt[i] = (CW'(i) < count_r) && (last_r[i] < cur_last_r);
      if ((CW'(i) < count_r) && (last_r[i] == cur_last_r)) dup_nxt = 1'b1;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    exp_nxt         = exp_r;
    ins_en          = 1'b0;
    drop_en         = 1'b0;
    pend_load       = 1'b0;
    pend_forced_nxt = pend_forced_r;
    pend_v_nxt      = pend_v_r;
    out_push        = 1'b0;
    out_last        = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (q_valid) state_nxt = B_FIND;
      end
      B_FIND: state_nxt = B_INS;
      B_INS: begin
        if (do_hold) begin
          ins_en    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
        state_nxt = (exp_r == '0) ? B_IDLE : B_REL;
      end
      B_REL: begin
        if (count_r == '0) begin
          state_nxt = pend_v_r ? B_FLUSH : B_IDLE;
        end else if (last_r[0] < exp_r) begin
          drop_en   = 1'b1;
          count_nxt = count_r - CW'(1);
        end else if ((first_r[0] <= exp_r) ||
                     ({6'd0, count_r} > {{CW{1'b0}}, limit_r})) begin
          if (!(pend_v_r && out_busy)) begin
            out_push        = pend_v_r;
            pend_load       = 1'b1;
            pend_v_nxt      = 1'b1;
            pend_forced_nxt = !(first_r[0] <= exp_r);
            exp_nxt         = head_next_seq;
            drop_en         = 1'b1;
            count_nxt       = count_r - CW'(1);
            // wrap to zero drops sync and ends the pass
            if (head_next_seq == '0) state_nxt = B_FLUSH;
          end
        end else begin
          state_nxt = pend_v_r ? B_FLUSH : B_IDLE;
        end
      end
      B_FLUSH: begin
        if (!out_busy) begin
          out_push   = 1'b1;
          out_last   = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    if (cfg_we && (cfg_index == CFG_START_SEQ)) exp_nxt = cfg_data;
    out_v_nxt = out_push ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      count_r  <= '0;
      exp_r    <= '0;
      limit_r  <= HOLD_LIMIT_RESET;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      exp_r    <= exp_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      if (cfg_we && (cfg_index == CFG_HOLD_LIMIT)) limit_r <= cfg_data[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      {cur_first_r, cur_last_r, cur_handle_r, cur_feed_r} <= q_data;
    end
    lt_r  <= lt_nxt;
    dup_r <= dup_nxt;
    if (pend_load) begin
      pend_first_r  <= first_r[0];
      pend_last_r   <= last_r[0];
      pend_handle_r <= handle_r[0];
      pend_feed_r   <= src_r[0];
      pend_forced_r <= pend_forced_nxt;
    end
    if (out_push) begin
      out_ch.out_first_seq <= pend_first_r;
      out_ch.out_last_seq  <= pend_last_r;
      out_ch.out_handle    <= pend_handle_r;
      out_ch.out_feed      <= pend_feed_r;
      out_ch.forced_jump   <= pend_forced_r;
      out_ch.last_of_run   <= out_last;
    end
  end

  assign out_ch.valid = out_v_r;

  // per-slot shift: up on insert, down on head removal
  for (genvar g = 0; g < HOLD_DEPTH; g++) begin : g_slot
    logic ins_here;
    if (g == 0) begin : g_first
      assign ins_here = !lt_r[0];
    end else begin : g_rest
      assign ins_here = lt_r[g-1] && !lt_r[g];
    end
    always_ff @(posedge clk) begin
      if (ins_en && !lt_r[g]) begin
        if (ins_here) begin
          last_r[g]   <= cur_last_r;
          first_r[g]  <= cur_first_r;
          handle_r[g] <= cur_handle_r;
          src_r[g]    <= cur_feed_r;
        end else begin
          last_r[g]   <= last_r[(g > 0) ? g - 1 : 0];
          first_r[g]  <= first_r[(g > 0) ? g - 1 : 0];
          handle_r[g] <= handle_r[(g > 0) ? g - 1 : 0];
          src_r[g]    <= src_r[(g > 0) ? g - 1 : 0];
        end
      end else if (drop_en && (g < HOLD_DEPTH - 1)) begin
        last_r[g]   <= last_r[(g < HOLD_DEPTH - 1) ? g + 1 : g];
        first_r[g]  <= first_r[(g < HOLD_DEPTH - 1) ? g + 1 : g];
        handle_r[g] <= handle_r[(g < HOLD_DEPTH - 1) ? g + 1 : g];
        src_r[g]    <= src_r[(g < HOLD_DEPTH - 1) ? g + 1 : g];
      end
    end
  end

  `SRGR_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(HOLD_DEPTH))
  `SRGR_ASSERT_ALWAYS(a_idle_no_pend, (state_r != B_IDLE) || !pend_v_r)
  `SRGR_ASSERT_ALWAYS(a_flush_has_pend, (state_r != B_FLUSH) || pend_v_r)
  `SRGR_ASSERT_NEXT(a_dup_no_grow, (state_r == B_INS) && dup_r, count_r == $past(count_r))
endmodule

@@ hw/rtl/sequence_reorder_gap_release_core.sv @@
// Top level of the two-feed sequence reorder buffer with gap release.
// Depends on srgr_pkg, srgr_in_if, srgr_out_if, srgr_front and srgr_back.
//
// Usage:
//   in_ch  : update words (span_first, last_seq, handle, feed), valid/ready.
//   out_ch : released words, in ascending last_seq; last_of_run marks the
//            final release caused by one update word.
//   cfg    : cfg_we/cfg_index/cfg_data; index 0 loads start_seq (and the
//            expected number), index 1 sets hold_limit. Write while idle.
// Timing: a two-entry front queue takes a word per cycle while it has room.
//   Per word the back end pops it, compares it against the store and does
//   the sorted insert, then walks the store from its head, discarding stale
//   entries and releasing in-order or forced ones, sees the pass end and
//   hands the final release to the output register; while not synchronized
//   it skips the release pass. It pops a new word only from its idle state,
//   so it finishes one word before it takes the next.
// Reset: expected number zero (not synchronized), store empty, hold_limit 63.
// Stall: a stalled receiver holds the output register; the back end keeps
//   one more release pending and then waits, and the front queue fills.
module sequence_reorder_gap_release_core #(
  parameter int HOLD_DEPTH  = 64,
  parameter int SEQ_BITS    = 48,
  parameter int HANDLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  srgr_in_if.sink             in_ch,
  srgr_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [SEQ_BITS-1:0] cfg_data
);
  localparam int QW = 2 * SEQ_BITS + HANDLE_BITS + 1;

  logic          q_valid;
  logic [QW-1:0] q_data;
  logic          q_pop;

  srgr_front #(.SEQ_BITS(SEQ_BITS), .HANDLE_BITS(HANDLE_BITS), .QW(QW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  srgr_back #(
    .HOLD_DEPTH  (HOLD_DEPTH),
    .SEQ_BITS    (SEQ_BITS),
    .HANDLE_BITS (HANDLE_BITS),
    .QW          (QW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ch    (out_ch)
  );
endmodule

@@ dv/sequence_reorder_gap_release_core_tb.sv @@
// Self-checking testbench for sequence_reorder_gap_release_core.
// Depends on srgr_pkg, srgr_in_if, srgr_out_if and the core RTL; a built-in
// predictor of the reorder store checks every released word in order.
module sequence_reorder_gap_release_core_tb;
  import srgr_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [47:0] SEQ_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [47:0] span_first;
    logic [47:0] last_seq;
    logic [15:0] handle;
    logic        feed;
  } update_t;

  typedef struct packed {
    update_t upd;
    logic    forced;
    logic    run_end;
  } release_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [47:0] cfg_data;

  srgr_in_if  #(.SEQ_BITS(48), .HANDLE_BITS(16)) in_ch ();
  srgr_out_if #(.SEQ_BITS(48), .HANDLE_BITS(16)) out_ch ();

  sequence_reorder_gap_release_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  update_t     held[DEPTH];
  int          n_held = 0;
  logic [47:0] next_seq = '0;
  logic [5:0]  gap_limit = HOLD_LIMIT_RESET;
  release_t    release_q[$];

  update_t     update_q[$];
  int          err_cnt = 0;
  bit          no_idle;
  int          long_stall_req;
  int          long_stall_ack;
  int          stall_left;
  int          quiet_cycles;
  logic [47:0] cursor;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [47:0] rnd_seq();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic void pop_oldest_held();
    for (int k = 1; k < n_held; k++) held[k-1] = held[k];
    n_held--;
  endfunction

  function automatic void predict_release(update_t u);
    int pos;
    int cnt;
    logic forced;
    release_t r;
    if (!(next_seq != 0 && u.last_seq < next_seq)) begin
      pos = 0;
      while (pos < n_held && held[pos].last_seq < u.last_seq) pos++;
      if (!(pos < n_held && held[pos].last_seq == u.last_seq) && n_held < DEPTH) begin
        for (int k = n_held; k > pos; k--) held[k] = held[k-1];
        held[pos] = u;
        n_held++;
      end
    end
    if (next_seq == 0) return;
    cnt = 0;
    while (n_held > 0) begin
      if (held[0].last_seq < next_seq) begin
        pop_oldest_held();
        continue;
      end
      if (held[0].span_first <= next_seq) forced = 1'b0;
      else if (n_held > gap_limit) forced = 1'b1;
      else break;
      r.upd = held[0];
      r.forced = forced;
      r.run_end = 1'b0;
      release_q = {release_q, r};
      cnt++;
      next_seq = held[0].last_seq + 48'd1;
      pop_oldest_held();
      if (next_seq == 0) break;
    end
    if (cnt > 0) release_q[release_q.size()-1].run_end = 1'b1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (update_q.size() > 0 && (no_idle || $urandom_range(99) >= 28)) begin
        update_t u;
        u = update_q.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.span_first <= u.span_first;
        in_ch.last_seq   <= u.last_seq;
        in_ch.handle     <= u.handle;
        in_ch.feed       <= u.feed;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, with one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      long_stall_ack <= 0;
    end else if (long_stall_req != long_stall_ack) begin
      long_stall_ack <= long_stall_req;
      stall_left <= 300;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || $urandom_range(99) >= 28;
    end
  end

  // monitor: check releases, then predict from the accepted word
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (release_q.size() == 0) begin
          $error("unexpected release word last_seq=%h", out_ch.out_last_seq);
          err_cnt++;
        end else begin
          release_t r;
          r = release_q.pop_front();
          if (out_ch.out_first_seq !== r.upd.span_first) begin
            $error("out_first_seq exp %h got %h", r.upd.span_first, out_ch.out_first_seq);
            err_cnt++;
          end
          if (out_ch.out_last_seq !== r.upd.last_seq) begin
            $error("out_last_seq exp %h got %h", r.upd.last_seq, out_ch.out_last_seq);
            err_cnt++;
          end
          if (out_ch.out_handle !== r.upd.handle) begin
            $error("out_handle exp %h got %h", r.upd.handle, out_ch.out_handle);
            err_cnt++;
          end
          if (out_ch.out_feed !== r.upd.feed) begin
            $error("out_feed exp %b got %b", r.upd.feed, out_ch.out_feed);
            err_cnt++;
          end
          if (out_ch.forced_jump !== r.forced) begin
            $error("forced_jump exp %b got %b", r.forced, out_ch.forced_jump);
            err_cnt++;
          end
          if (out_ch.last_of_run !== r.run_end) begin
            $error("last_of_run exp %b got %b", r.run_end, out_ch.last_of_run);
            err_cnt++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_release('{in_ch.span_first, in_ch.last_seq, in_ch.handle, in_ch.feed});
      if (cfg_we) begin
        if (cfg_index == CFG_START_SEQ) next_seq = cfg_data;
        else gap_limit = cfg_data[5:0];
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 3000) begin
      $display("sequence_reorder_gap_release_core_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [47:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic push_word(input logic [47:0] f, input logic [47:0] l,
                           input logic [15:0] h, input logic fd);
    update_q = {update_q, update_t'{f, l, h, fd}};
  endtask

  // wait until every word went in and every release came out, then let
  // the back end finish discarding stale entries
  task automatic drain();
    while (update_q.size() > 0 || in_ch.valid || release_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // contiguous deltas from the cursor, with gaps, local reordering,
  // repeats from the other feed, stale repeats and some random noise
  task automatic push_stream(input int n);
    update_t lst[$];
    update_t u;
    update_t tmp;
    int len;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) begin
        u = '{rnd_seq(), rnd_seq(), 16'($urandom), 1'($urandom)};
        lst = {lst, u};
        continue;
      end
      if ($urandom_range(99) < 12) cursor = cursor + 48'($urandom_range(1, 6));
      len = $urandom_range(1, 4);
      u = '{cursor, cursor + 48'(len - 1), 16'($urandom), 1'($urandom)};
      cursor = cursor + 48'(len);
      lst = {lst, u};
      if ($urandom_range(99) < 25) begin
        u.feed = ~u.feed;
        u.handle = 16'($urandom);
        lst = {lst, u};
      end
      if ($urandom_range(99) < 6) begin
        u.span_first = u.span_first - 48'd20;
        u.last_seq = u.last_seq - 48'd10;
        lst = {lst, u};
      end
    end
    for (int i = 1; i < lst.size(); i++)
      if ($urandom_range(99) < 30) begin
        tmp = lst[i]; lst[i] = lst[i-1]; lst[i-1] = tmp;
      end
    foreach (lst[i]) update_q = {update_q, lst[i]};
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_START_SEQ;
    cfg_data = '0;
    no_idle = 1'b0;
    long_stall_req = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // not synchronized: extremes, inverted range, repeats, then store full
    push_word(48'd0, 48'd0, 16'h0000, 1'b0);
    push_word(SEQ_MAX, SEQ_MAX, 16'hFFFF, 1'b1);
    push_word(48'd2005, 48'd2001, 16'h1234, 1'b0);
    push_word(48'd2000, 48'd2001, 16'h4321, 1'b1);
    push_word(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 16'hA5A5, 1'b0);
    push_word(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 16'h5A5A, 1'b1);
    for (int i = 0; i < 62; i++)
      push_word(48'(1000 + 2 * i), 48'(1001 + 2 * i), 16'($urandom), 1'($urandom));
    drain();

    write_reg(CFG_START_SEQ, 48'd1000);
    write_reg(CFG_HOLD_LIMIT, 48'd63);
    cursor = 48'd1124;
    push_stream(12);
    drain();

    write_reg(CFG_HOLD_LIMIT, 48'd0);
    push_stream(12);
    drain();

    // long receiver hold-off while words keep coming
    write_reg(CFG_HOLD_LIMIT, 48'd5);
    long_stall_req = long_stall_req + 1;
    push_stream(18);
    drain();

    no_idle = 1'b1;
    write_reg(CFG_HOLD_LIMIT, 48'd63);
    push_stream(12);
    drain();
    no_idle = 1'b0;

    // run through the top of the sequence space
    write_reg(CFG_START_SEQ, SEQ_MAX - 48'd12);
    write_reg(CFG_HOLD_LIMIT, 48'd3);
    cursor = SEQ_MAX - 48'd12;
    push_stream(10);
    drain();

    write_reg(CFG_START_SEQ, SEQ_MAX);
    write_reg(CFG_HOLD_LIMIT, 48'd1);
    push_word(SEQ_MAX, SEQ_MAX, 16'hBEEF, 1'b1);
    cursor = 48'd1;
    push_stream(6);
    drain();

    write_reg(CFG_START_SEQ, 48'd0);
    push_stream(4);
    drain();
    write_reg(CFG_START_SEQ, 48'd1);
    write_reg(CFG_HOLD_LIMIT, 48'd2);
    push_stream(6);
    drain();

    if (err_cnt == 0)
      $display("sequence_reorder_gap_release_core_tb: clean");
    else
      $display("sequence_reorder_gap_release_core_tb: errors");
    $finish;
  end
endmodule
